// ----- rtl/core/hmp_pkg.sv -----
// Shared types and helpers for the hash message padder.
// Used by the front, queue users and back of the padder; no dependencies.
package hmp_pkg;

  localparam logic [7:0] PAD_MARKER = 8'h80;

  // Word indexes within a 64-byte and a 128-byte block
  localparam logic [3:0] LAST_WORD_NARROW = 4'd7;
  localparam logic [3:0] LAST_WORD_WIDE   = 4'd15;
  localparam logic [3:0] LEN_WORD_WIDE    = 4'd14;

  // Configuration register indexes
  localparam logic CFG_LENGTH_LITTLE_ENDIAN = 1'b0;
  localparam logic CFG_WIDE_BLOCK           = 1'b1;

  typedef struct packed {
    logic le;
    logic wide;
  } hmp_cfg_t;

  // One queue entry: a finished data word, a padding request, or both
  typedef struct packed {
    logic        is_pad;
    logic        word_valid;
    logic [63:0] word;
    logic        word_be;
    logic [55:0] partial;
    logic [2:0]  fill;
    logic [60:0] total;
    hmp_cfg_t    cfg;
  } hmp_entry_t;

  function automatic logic [63:0] byte_swap64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/hmp_fifo.sv -----
// Short register queue between the padder front and back.
// Generic width and depth; no package dependencies.
module hmp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/hmp_front.sv -----
// Padder front: takes message bytes, packs words, counts bytes, queues work.
// Depends on hmp_pkg.
module hmp_front (
  input  logic               clk,
  input  logic               rst,
  input  hmp_pkg::hmp_cfg_t  cfg,
  input  logic               in_accept,
  input  logic [7:0]         data_byte,
  input  logic               byte_present,
  input  logic               message_end,
  output logic               push,
  output hmp_pkg::hmp_entry_t push_entry
);
  import hmp_pkg::*;

  logic [60:0] byte_total;
  logic [55:0] partial_word;
  logic [2:0]  partial_fill;

  logic [60:0] total_next;
  logic [55:0] partial_next;
  logic [2:0]  fill_next;
  logic        word_done;
  logic        word_be;

  always_comb begin
    total_next   = byte_total;
    partial_next = partial_word;
    fill_next    = partial_fill;
    word_done    = 1'b0;
    if (byte_present) begin
      total_next = byte_total + 61'd1;
      if (partial_fill == 3'd7) begin
        word_done    = 1'b1;
        partial_next = '0;
        fill_next    = '0;
      end else begin
        partial_next = {partial_word[47:0], data_byte};
        fill_next    = partial_fill + 3'd1;
      end
    end
    word_be = cfg.wide ? (total_next[6:0] == '0) : (total_next[5:0] == '0);
  end

  assign push = in_accept && (word_done || message_end);

  always_comb begin
    push_entry.is_pad     = message_end;
    push_entry.word_valid = word_done;
    push_entry.word       = {partial_word, data_byte};
    push_entry.word_be    = word_be;
    push_entry.partial    = partial_next;
    push_entry.fill       = fill_next;
    push_entry.total      = total_next;
    push_entry.cfg        = cfg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total   <= '0;
      partial_word <= '0;
      partial_fill <= '0;
    end else if (in_accept) begin
      if (message_end) begin
        // new message starts from scratch
        byte_total   <= '0;
        partial_word <= '0;
        partial_fill <= '0;
      end else begin
        byte_total   <= total_next;
        partial_word <= partial_next;
        partial_fill <= fill_next;
      end
    end
  end

endmodule

// ----- rtl/core/hmp_back.sv -----
// Padder back: drains the queue, emits data words and the padding sequence.
// Depends on hmp_pkg; drives the output word register.
module hmp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  hmp_pkg::hmp_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_word,
  output logic                block_end,
  output logic                padded_last
);
  import hmp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_PAD  = 2'b10
  } state_t;

  state_t      state;
  hmp_entry_t  ent;
  logic [3:0]  widx;
  logic        first;
  logic        final_blk;

  logic        can_load;
  logic [3:0]  last_word;
  logic [3:0]  start_word;
  logic [63:0] bits;
  logic [63:0] len_word;
  logic [63:0] first_word;
  logic [63:0] pad_word;
  logic        pad_last;
  logic [5:0]  shamt;

  assign can_load = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && can_load && !q_empty;

  assign last_word = ent.cfg.wide ? LAST_WORD_WIDE : LAST_WORD_NARROW;
  assign bits      = {ent.total, 3'b000};
  assign shamt     = {3'd7 - ent.fill, 3'b000};

  always_comb begin
    first_word = {ent.partial, PAD_MARKER} << shamt;
    len_word   = '0;
    if (ent.cfg.wide) begin
      // upper eight length bytes are zero: first for big-endian, last for little
      if (widx == LEN_WORD_WIDE) begin
        len_word = ent.cfg.le ? byte_swap64(bits) : '0;
      end else begin
        len_word = ent.cfg.le ? '0 : bits;
      end
    end else begin
      len_word = ent.cfg.le ? byte_swap64(bits) : bits;
    end
    if (first) begin
      pad_word = first_word;
    end else if (final_blk && (widx == last_word ||
                 (ent.cfg.wide && widx == LEN_WORD_WIDE))) begin
      pad_word = len_word;
    end else begin
      pad_word = '0;
    end
    pad_last = final_blk && (widx == last_word);
  end

  // word index of the marker byte within its block
  assign start_word = q_entry.cfg.wide ? q_entry.total[6:3] : {1'b0, q_entry.total[5:3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            // a pad-only entry leaves the output empty for one cycle
            out_valid <= q_entry.word_valid;
            if (q_entry.is_pad) begin
              state <= S_PAD;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_PAD: begin
          if (can_load) begin
            out_valid <= 1'b1;
            if (pad_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          ent         <= q_entry;
          out_word    <= q_entry.word;
          block_end   <= q_entry.word_be;
          padded_last <= 1'b0;
          widx        <= start_word;
          first       <= 1'b1;
          // marker fits ahead of the length field in this block
          final_blk   <= q_entry.cfg.wide ? (start_word < LEN_WORD_WIDE)
                                          : (start_word != LAST_WORD_NARROW);
        end
      end
      S_PAD: begin
        if (can_load) begin
          out_word    <= pad_word;
          block_end   <= (widx == last_word);
          padded_last <= pad_last;
          first       <= 1'b0;
          if (widx == last_word) begin
            widx      <= '0;
            final_blk <= 1'b1;
          end else begin
            widx <= widx + 4'd1;
          end
        end
      end
      default: begin
        first <= 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/hash_message_padder_top.sv -----
// Top level of the hash message padder: config registers, front, queue, back.
// Depends on hmp_pkg, hmp_front, hmp_fifo and hmp_back.

// Merkle-Damgard padder for MD5 and the SHA family. One message byte is taken
// per cycle while the internal queue has room; every eighth byte yields a
// 64-bit output word, earliest byte in the top bits. On the word that carries
// tlast the padding follows: 0x80, zeros, then the bit count (little- or
// big-endian per register 0, 8 or 16 bytes per register 1) until the block
// closes. The back end emits one padding word per cycle while the output is
// taken, after an empty output slot (or after the data word finished by the
// same item); a padding run is 2 to 18 words, during which the back end takes
// no queue entry, and input stalls once the QUEUE_DEPTH-entry queue fills
// behind it. Output words are held in a register until taken.
module hash_message_padder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // message_end
  input  logic        s_axis_tuser,   // [0] byte_present
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] out_word
  output logic        m_axis_tlast,   // padded_last
  output logic        m_axis_tuser    // [0] block_end
);
  import hmp_pkg::*;

  hmp_cfg_t   cfg;
  logic       in_accept;
  logic       push;
  hmp_entry_t push_entry;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  hmp_entry_t q_entry;
  logic [$bits(hmp_entry_t)-1:0] q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LENGTH_LITTLE_ENDIAN: cfg.le   <= cfg_wdata;
        CFG_WIDE_BLOCK:           cfg.wide <= cfg_wdata;
        default:                  cfg      <= cfg;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  hmp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_accept    (in_accept),
    .data_byte    (s_axis_tdata),
    .byte_present (s_axis_tuser),
    .message_end  (s_axis_tlast),
    .push         (push),
    .push_entry   (push_entry)
  );

  hmp_fifo #(
    .WIDTH ($bits(hmp_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  assign q_entry = hmp_entry_t'(q_data);

  hmp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_word    (m_axis_tdata),
    .block_end   (m_axis_tuser),
    .padded_last (m_axis_tlast)
  );

endmodule

// ----- test/hash_message_padder_checker.sv -----
`timescale 1ns / 100ps
// Checker for the hash message padder: snoops the register port and both streams,
// computes the padded words each accepted byte item must yield and compares them.
// Depends on hmp_pkg for the register indexes and the padding marker.
module hash_message_padder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  output int          errors,
  output int          pending
);
  import hmp_pkg::*;

  typedef struct packed {
    logic [63:0] word;
    logic        blk_end;
    logic        last;
  } padded_word_t;

  padded_word_t padded_words[$];

  logic        cfg_le;
  logic        cfg_wide;
  logic [60:0] msg_bytes;
  logic [55:0] pend_bytes;
  logic [2:0]  pend_count;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= 40) begin
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
    end
  endtask

  // Shift one byte into the packer; a full word goes to the expected queue.
  task automatic pack_byte(input logic [7:0] b, input logic at_end, input logic is_last);
    padded_word_t w;
    if (pend_count < 3'd7) begin
      pend_bytes = {pend_bytes[47:0], b};
      pend_count = pend_count + 3'd1;
    end else begin
      w.word    = {pend_bytes, b};
      w.blk_end = at_end;
      w.last    = is_last;
      padded_words = {padded_words, w};
      pend_bytes = '0;
      pend_count = '0;
    end
  endtask

  task automatic pad_item(input logic [7:0] d, input logic present, input logic ending);
    logic [6:0]  mask;
    logic [6:0]  pos;
    logic [6:0]  pad_stop;
    logic [63:0] bit_count;
    logic [7:0]  b;
    int          len_bytes;
    int          sig;
    mask      = cfg_wide ? 7'd127 : 7'd63;
    len_bytes = cfg_wide ? 16 : 8;
    pad_stop  = mask - 7'(len_bytes - 1);
    if (present) begin
      msg_bytes = msg_bytes + 61'd1;
      pos = msg_bytes[6:0] & mask;
      pack_byte(d, pos == '0, 1'b0);
    end
    if (ending) begin
      bit_count = {msg_bytes, 3'b000};
      pos = (msg_bytes[6:0] + 7'd1) & mask;
      pack_byte(PAD_MARKER, pos == '0, 1'b0);
      while (pos != pad_stop) begin
        pos = (pos + 7'd1) & mask;
        pack_byte(8'h00, pos == '0, 1'b0);
      end
      // upper half of a 16-byte length field is always zero
      for (int i = 0; i < len_bytes; i++) begin
        sig = cfg_le ? i : len_bytes - 1 - i;
        b   = (sig < 8) ? 8'(bit_count >> (8 * sig)) : 8'h00;
        pos = (pos + 7'd1) & mask;
        pack_byte(b, pos == '0, i == len_bytes - 1);
      end
      msg_bytes  = '0;
      pend_bytes = '0;
      pend_count = '0;
    end
  endtask

  always @(posedge clk) begin
    padded_word_t want;
    if (rst) begin
      cfg_le     = 1'b0;
      cfg_wide   = 1'b0;
      msg_bytes  = '0;
      pend_bytes = '0;
      pend_count = '0;
      padded_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LENGTH_LITTLE_ENDIAN) begin
          cfg_le = cfg_wdata;
        end else if (cfg_index == CFG_WIDE_BLOCK) begin
          cfg_wide = cfg_wdata;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pad_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (padded_words.size() == 0) begin
          report_mismatch("word with nothing expected", m_axis_tdata, '0);
        end else begin
          want = padded_words.pop_front();
          if (m_axis_tdata !== want.word) begin
            report_mismatch("out_word", m_axis_tdata, want.word);
          end
          if (m_axis_tuser !== want.blk_end) begin
            report_mismatch("block_end", 64'(m_axis_tuser), 64'(want.blk_end));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch("padded_last", 64'(m_axis_tlast), 64'(want.last));
          end
        end
      end
    end
    pending <= padded_words.size();
  end

endmodule

// ----- test/hash_message_padder_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the hash message padder: clock, reset, register writes,
// byte stream stimulus and output back-pressure; checking is in the checker module.
// Depends on hmp_pkg, hash_message_padder_top and hash_message_padder_checker.
module hash_message_padder_top_tb;
  import hmp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;   // message_end
  logic        s_axis_tuser = 1'b0;   // [0] byte_present
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;          // [63:0] out_word
  logic        m_axis_tlast;          // padded_last
  logic        m_axis_tuser;          // [0] block_end

  int errors;
  int pending;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_start = 1'b0;

  // current message of the random stream
  bit msg_open = 1'b0;
  bit end_split = 1'b0;
  int msg_left = 0;

  hash_message_padder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  hash_message_padder_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offer one byte item and hold it until the block takes it.
  task automatic send_word(input logic [7:0] d, input logic p, input logic e);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= p;
    s_axis_tlast  <= e;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic set_config(input logic le, input logic wide);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LENGTH_LITTLE_ENDIAN;
    cfg_wdata <= le;
    @(posedge clk);
    cfg_index <= CFG_WIDE_BLOCK;
    cfg_wdata <= wide;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every expected word, then let any partial bytes clear the queue.
  task automatic drain_output();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Mostly well-formed messages of random length; a few empty items as noise.
  task automatic next_item(output logic [7:0] d, output logic p, output logic e,
                           output bit counts);
    int r;
    int len;
    d = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 6) begin
      p      = 1'b0;
      e      = 1'b0;
      counts = 1'b0;
    end else begin
      counts = 1'b1;
      if (!msg_open) begin
        r = $urandom_range(99);
        if (r < 70) begin
          len = $urandom_range(10);
        end else if (r < 92) begin
          len = $urandom_range(68, 52);
        end else begin
          len = $urandom_range(124, 108);
        end
        msg_left  = len;
        end_split = (len == 0) || ($urandom_range(3) == 0);
        msg_open  = 1'b1;
      end
      if (msg_left > 0) begin
        p = 1'b1;
        msg_left--;
        e = (msg_left == 0) && !end_split;
      end else begin
        p = 1'b0;
        e = 1'b1;
      end
      if (e) begin
        msg_open = 1'b0;
      end
      if ($urandom_range(9) == 0) begin
        d = $urandom_range(1) ? 8'hFF : 8'h00;
      end
    end
  endtask

  initial begin
    logic [7:0] d;
    logic       p;
    logic       e;
    bit         counts;
    int         sent;
    int         waited;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message, then an item that carries nothing
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 1'b0, 1'b0);
    // two-byte message ending on its last byte
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    // message end on an item of its own
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);
    // exactly one full word of message
    for (int i = 0; i < 8; i++) begin
      send_word(8'(i * 37 + 1), 1'b1, i == 7);
    end
    send_word(8'hA5, 1'b0, 1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      drain_output();
      set_config(phase[1], phase[0] ^ phase[2]);
      case (phase % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 87;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 87;
        end
        default: begin
          src_idle_pct   = 13;
          sink_stall_pct = 13;
        end
      endcase
      // block the output for a while so the queue fills and input stalls
      if (phase == 0) begin
        hold_start = 1'b1;
      end
      sent = 0;
      while (sent < 30) begin
        next_item(d, p, e, counts);
        send_word(d, p, e);
        if (counts) begin
          sent++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    if (pending == 0) begin
      repeat (64) @(posedge clk);
    end
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/hmp_pkg.sv
rtl/core/hmp_fifo.sv
rtl/core/hmp_front.sv
rtl/core/hmp_back.sv
rtl/core/hash_message_padder_top.sv
test/hash_message_padder_checker.sv
test/hash_message_padder_top_tb.sv
